@@ src/quicksort_engine_defines.svh @@
// assertion macros for the sorter
`ifndef QUICKSORT_ENGINE_DEFINES_SVH
`define QUICKSORT_ENGINE_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define QSE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quicksort_engine: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define QSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quicksort_engine: next-cycle check failed");

`else

`define QSE_ASSERT_SAME(label, ante, cons)
`define QSE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/qse_pkg.sv @@
package qse_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     dropped;
    } t_out_item;

    // one value moving along the row, or held in a cell
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } t_link;

    typedef struct packed {
        logic shift;
    } t_cell_ctl;

endpackage

@@ src/qse_cell.sv @@
module qse_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qse_pkg::t_cell_ctl i_ctl,
    input  qse_pkg::t_link    i_pass,
    input  qse_pkg::t_link    i_right_held,
    output qse_pkg::t_link    o_pass,
    output qse_pkg::t_link    o_held
);
    import qse_pkg::*;

    logic              r_held_valid;
    logic [DATA_W-1:0] r_held_value;
    logic              r_pass_valid;
    logic [DATA_W-1:0] r_pass_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_pass_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_held_valid <= i_right_held.valid;
            r_held_value <= i_right_held.value;
            r_pass_valid <= 1'b0;
        end else if (i_pass.valid) begin
            if (!r_held_valid) begin
                r_held_valid <= 1'b1;
                r_held_value <= i_pass.value;
                r_pass_valid <= 1'b0;
            end else if ($signed(i_pass.value) < $signed(r_held_value)) begin
                // keep the smaller value, push the held one right
                r_held_value <= i_pass.value;
                r_pass_valid <= 1'b1;
                r_pass_value <= r_held_value;
            end else begin
                r_pass_valid <= 1'b1;
                r_pass_value <= i_pass.value;
            end
        end else begin
            r_pass_valid <= 1'b0;
        end
    end

    assign o_pass = '{valid: r_pass_valid, value: r_pass_value};
    assign o_held = '{valid: r_held_valid, value: r_held_value};

endmodule

@@ src/qse_chain.sv @@
module qse_chain #(
    parameter int MAX_ITEMS = qse_pkg::MAX_ITEMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qse_pkg::t_cell_ctl i_ctl,
    input  qse_pkg::t_link     i_insert,
    output qse_pkg::t_link     o_head
);
    import qse_pkg::*;

    t_link w_pass [MAX_ITEMS+1];
    t_link w_held [MAX_ITEMS+1];

    assign w_pass[0]         = i_insert;
    assign w_held[MAX_ITEMS] = '{valid: 1'b0, value: '0};

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        qse_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_pass       (w_pass[g]),
            .i_right_held (w_held[g+1]),
            .o_pass       (w_pass[g+1]),
            .o_held       (w_held[g])
        );
    end

    // the last cell's pass output is left unconnected: the row holds at most MAX_ITEMS values
    assign o_head = w_held[0];

endmodule

@@ src/quicksort_engine.sv @@
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | i_data (value, last_in)
// output  | out       | o_valid / i_stall  | o_data (sorted_value, last_out, dropped)
//
// while loading, each accepted transfer with room left enters a row of MAX_ITEMS
// insertion cells that keep the smallest value at the head; values beyond that are dropped.
// after the item marked last, the row settles in S_SETTLE, then in S_DRAIN the
// row shifts out one result per cycle while the output is not stalled, then
// returns to loading.
// synchronous active-low reset empties the row and returns to loading.
// o_stall is high outside loading: from after the last input transfer until the drain
// finds the row empty and returns to loading.
`include "quicksort_engine_defines.svh"

module quicksort_engine #(
    parameter int MAX_ITEMS = qse_pkg::MAX_ITEMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  qse_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output qse_pkg::t_out_item o_data
);
    import qse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SET_W = $clog2(MAX_ITEMS);
    localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_ITEMS);
    localparam logic [SET_W-1:0] SETTLE_LAST = SET_W'(MAX_ITEMS - 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SETTLE,
        S_DRAIN
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [SET_W-1:0]   r_settle;
    logic               r_ovf;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic      w_accept;
    logic      w_room;
    logic      w_shift;
    t_link     w_insert;
    t_link     w_head;
    t_cell_ctl w_ctl;

    assign o_stall  = (r_state != S_LOAD);
    assign w_accept = i_valid && !o_stall;
    assign w_room   = (r_count < MAX_CNT);
    assign w_insert = '{valid: w_accept && w_room, value: i_data.value};
    assign w_shift  = (r_state == S_DRAIN) && (r_count != '0) && (!r_out_valid || !i_stall);
    assign w_ctl    = '{shift: w_shift};

    qse_chain #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_insert (w_insert),
        .o_head   (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_settle    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_data.last_in) begin
                            r_state  <= S_SETTLE;
                            r_settle <= '0;
                        end
                    end
                end
                S_SETTLE: begin
                    if (r_settle == SETTLE_LAST) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_settle <= r_settle + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_count == '0) begin
                        r_state <= S_LOAD;
                        r_ovf   <= 1'b0;
                    end else if (w_shift) begin
                        r_count <= r_count - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            if (w_shift) begin
                r_out_valid <= 1'b1;
                r_out_data  <= '{sorted_value: w_head.value,
                                 last_out:     (r_count == CNT_W'(1)),
                                 dropped:      r_ovf};
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    `QSE_ASSERT_SAME(a_count_bound, 1'b1, r_count <= MAX_CNT)
    `QSE_ASSERT_SAME(a_head_occupied, w_shift, w_head.valid)
    `QSE_ASSERT_NEXT(a_drain_continues, o_valid && !i_stall && !o_data.last_out, o_valid)

endmodule
